### rtl/pat_pkg.sv
// Shared types and constants for the peer address table.
`default_nettype none

package pat_pkg;

  // Fixed field widths.
  localparam int unsigned ADDR_W       = 48;
  localparam int unsigned CMD_W        = 2;
  localparam int unsigned COUNT_OUT_W  = 5;

  // Default table depth.
  localparam int unsigned MAX_ENTRIES_DEF = 20;

  // Request opcodes.
  typedef enum logic [CMD_W-1:0] {
    OP_LOOKUP = 2'd0,
    OP_ADD    = 2'd1,
    OP_REMOVE = 2'd2,
    OP_CLEAR  = 2'd3
  } pat_op_e;

  // Controller states.
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_EXEC,
    ST_RM_RD,
    ST_RM_WR,
    ST_DONE
  } pat_state_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;
    logic scan;
    logic add;
    logic clear;
    logic rm_read;
    logic rm_write;
  } pat_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic match;
    logic scan_end;
  } pat_sts_t;

endpackage

`default_nettype wire

### rtl/pat_ctrl.sv
// Controller state machine that sequences the scan, update and result of a request.
`default_nettype none

module pat_ctrl (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         start,
  input  wire logic [pat_pkg::CMD_W-1:0]    command_i,
  input  wire pat_pkg::pat_sts_t            sts_i,
  output pat_pkg::pat_cmd_t                 cmd_o,
  output logic                              busy,
  output logic                              done_o
);

  pat_pkg::pat_state_e state_q, state_d;
  pat_pkg::pat_op_e    op_q, op_d;
  logic                accept;

  assign accept = start && (state_q == pat_pkg::ST_IDLE);

  // State and opcode registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= pat_pkg::ST_IDLE;
      op_q    <= pat_pkg::OP_LOOKUP;
    end else begin
      state_q <= state_d;
      op_q    <= op_d;
    end
  end

  // Next state logic.
  always_comb begin
    state_d = state_q;
    op_d    = op_q;
    case (state_q)
      pat_pkg::ST_IDLE: begin
        if (accept) begin
          state_d = pat_pkg::ST_SCAN;
          op_d    = pat_pkg::pat_op_e'(command_i);
        end
      end
      pat_pkg::ST_SCAN: begin
        if (sts_i.match || sts_i.scan_end) begin
          case (op_q)
            pat_pkg::OP_ADD:    state_d = pat_pkg::ST_EXEC;
            pat_pkg::OP_CLEAR:  state_d = pat_pkg::ST_EXEC;
            pat_pkg::OP_REMOVE: state_d = sts_i.match ? pat_pkg::ST_RM_RD : pat_pkg::ST_DONE;
            default:            state_d = pat_pkg::ST_DONE;
          endcase
        end
      end
      pat_pkg::ST_EXEC:  state_d = pat_pkg::ST_DONE;
      pat_pkg::ST_RM_RD: state_d = pat_pkg::ST_RM_WR;
      pat_pkg::ST_RM_WR: state_d = pat_pkg::ST_DONE;
      pat_pkg::ST_DONE:  state_d = pat_pkg::ST_IDLE;
      default:           state_d = pat_pkg::ST_IDLE;
    endcase
  end

  // Output decode.
  always_comb begin
    cmd_o    = '0;
    busy     = 1'b1;
    done_o   = 1'b0;
    case (state_q)
      pat_pkg::ST_IDLE: begin
        busy       = 1'b0;
        cmd_o.load = start;
      end
      pat_pkg::ST_SCAN:  cmd_o.scan = 1'b1;
      pat_pkg::ST_EXEC: begin
        cmd_o.add   = (op_q == pat_pkg::OP_ADD);
        cmd_o.clear = (op_q == pat_pkg::OP_CLEAR);
      end
      pat_pkg::ST_RM_RD: cmd_o.rm_read  = 1'b1;
      pat_pkg::ST_RM_WR: cmd_o.rm_write = 1'b1;
      pat_pkg::ST_DONE:  done_o = 1'b1;
      default:           busy = 1'b1;
    endcase
  end

endmodule

`default_nettype wire

### rtl/pat_dp.sv
// Datapath with the address memory, scan pipeline, live count and result registers.
`default_nettype none

module pat_dp #(
  parameter int unsigned MAX_ENTRIES = pat_pkg::MAX_ENTRIES_DEF
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic [pat_pkg::ADDR_W-1:0]    mac_address_i,
  input  wire pat_pkg::pat_cmd_t             cmd_i,
  output pat_pkg::pat_sts_t                  sts_o,
  output logic                               hit_o,
  output logic                               stored_o,
  output logic                               table_full_o,
  output logic [pat_pkg::COUNT_OUT_W-1:0]    entry_count_o
);

  localparam int unsigned IDX_W = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
  localparam int unsigned CNT_W = $clog2(MAX_ENTRIES + 1);
  localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_ENTRIES);

  logic [pat_pkg::ADDR_W-1:0] mem [MAX_ENTRIES];

  logic [pat_pkg::ADDR_W-1:0] addr_q;
  logic [pat_pkg::ADDR_W-1:0] rd_data_q;
  logic [CNT_W-1:0]           count_q;
  logic [CNT_W-1:0]           rd_idx_q;
  logic [IDX_W-1:0]           pend_idx_q;
  logic [IDX_W-1:0]           pos_q;
  logic                       pend_q;
  logic                       hit_q;
  logic                       stored_q;
  logic                       full_q;

  logic                       issue_ok;
  logic                       match;
  logic [CNT_W-1:0]           last_cnt;
  logic                       rd_en;
  logic [IDX_W-1:0]           rd_addr;
  logic                       wr_en;
  logic [IDX_W-1:0]           wr_addr;
  logic [pat_pkg::ADDR_W-1:0] wr_data;
  logic                       add_ok;

  // Scan status.
  assign issue_ok = (rd_idx_q < count_q);
  assign match    = pend_q && (rd_data_q == addr_q);
  assign last_cnt = count_q - CNT_W'(1);
  assign add_ok   = !hit_q && (count_q < CNT_MAX);

  assign sts_o.match    = match;
  assign sts_o.scan_end = !issue_ok && !match;

  // Memory port selection: scan reads or the last-entry read for a remove, and writes for an add or a remove.
  always_comb begin
    rd_en   = (cmd_i.scan && issue_ok) || cmd_i.rm_read;
    rd_addr = cmd_i.rm_read ? last_cnt[IDX_W-1:0] : rd_idx_q[IDX_W-1:0];
    wr_en   = (cmd_i.add && add_ok) || cmd_i.rm_write;
    wr_addr = cmd_i.rm_write ? pos_q : count_q[IDX_W-1:0];
    wr_data = cmd_i.rm_write ? rd_data_q : addr_q;
  end

  // Address memory with registered read data.
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_q <= mem[rd_addr];
    end
  end

  // Request address and match position.
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      addr_q <= mac_address_i;
    end
    if (cmd_i.scan) begin
      pend_idx_q <= rd_idx_q[IDX_W-1:0];
      if (match) begin
        pos_q <= pend_idx_q;
      end
    end
  end

  // Control registers: scan pointer, live count and result flags.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q  <= '0;
      rd_idx_q <= '0;
      pend_q   <= 1'b0;
      hit_q    <= 1'b0;
      stored_q <= 1'b0;
      full_q   <= 1'b0;
    end else begin
      if (cmd_i.load) begin
        rd_idx_q <= '0;
        pend_q   <= 1'b0;
        hit_q    <= 1'b0;
        stored_q <= 1'b0;
        full_q   <= 1'b0;
      end
      if (cmd_i.scan) begin
        pend_q <= issue_ok;
        if (issue_ok) begin
          rd_idx_q <= rd_idx_q + CNT_W'(1);
        end
        if (match) begin
          hit_q <= 1'b1;
        end
      end
      if (cmd_i.add && !hit_q) begin
        if (add_ok) begin
          count_q  <= count_q + CNT_W'(1);
          stored_q <= 1'b1;
        end else begin
          full_q <= 1'b1;
        end
      end
      if (cmd_i.clear) begin
        count_q <= '0;
      end
      if (cmd_i.rm_read) begin
        count_q <= last_cnt;
      end
    end
  end

  assign hit_o         = hit_q;
  assign stored_o      = stored_q;
  assign table_full_o  = full_q;
  assign entry_count_o = pat_pkg::COUNT_OUT_W'(count_q);

endmodule

`default_nettype wire

### rtl/peer_address_table.sv
// Top level of the peer address table: controller plus datapath.
// One request at a time; the next can be taken in the cycle after done_o.
// The linear scan does one memory read and compare per cycle.
// The result is shown for one cycle on done_o; the receiver cannot stall.
// Reset clears the live count and control state; memory contents are left undefined.
`default_nettype none

module peer_address_table #(
  parameter int unsigned MAX_ENTRIES = pat_pkg::MAX_ENTRIES_DEF
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          start,
  output logic                               busy,
  input  wire logic [pat_pkg::CMD_W-1:0]     command_i,
  input  wire logic [pat_pkg::ADDR_W-1:0]    mac_address_i,
  output logic                               done_o,
  output logic                               hit_o,
  output logic                               stored_o,
  output logic                               table_full_o,
  output logic [pat_pkg::COUNT_OUT_W-1:0]    entry_count_o
);

  pat_pkg::pat_cmd_t cmd;
  pat_pkg::pat_sts_t sts;

  // Sequencer.
  pat_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start     (start),
    .command_i (command_i),
    .sts_i     (sts),
    .cmd_o     (cmd),
    .busy      (busy),
    .done_o    (done_o)
  );

  // Storage and compare datapath.
  pat_dp #(
    .MAX_ENTRIES (MAX_ENTRIES)
  ) u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .mac_address_i (mac_address_i),
    .cmd_i         (cmd),
    .sts_o         (sts),
    .hit_o         (hit_o),
    .stored_o      (stored_o),
    .table_full_o  (table_full_o),
    .entry_count_o (entry_count_o)
  );

endmodule

`default_nettype wire

### rtl/pat_checker.sv
// Port-level checker for the peer address table and its bind statement.
`default_nettype none

module pat_checker #(
  parameter int unsigned MAX_ENTRIES = pat_pkg::MAX_ENTRIES_DEF
) (
  input wire logic                          clk_i,
  input wire logic                          rst_ni,
  input wire logic                          start,
  input wire logic                          busy,
  input wire logic                          done_o,
  input wire logic                          hit_o,
  input wire logic                          stored_o,
  input wire logic                          table_full_o,
  input wire logic [pat_pkg::COUNT_OUT_W-1:0] entry_count_o
);

  localparam logic [pat_pkg::COUNT_OUT_W-1:0] MAX_SHOWN = pat_pkg::COUNT_OUT_W'(MAX_ENTRIES);

  // An accepted request keeps the block busy in the next cycle.
  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && !busy |=> busy)
    else $error("busy did not rise after an accepted request");

  // A result strobe lasts one cycle and is followed by the block going idle.
  a_done_pulse: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !done_o && !busy)
    else $error("result strobe not a single cycle before idle");

  // A stored add never reports a hit or a refusal.
  a_stored_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && stored_o |-> !hit_o && !table_full_o)
    else $error("stored flag together with hit or full");

  // A refused add means the table is full and the address was absent.
  a_full_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && table_full_o |-> !hit_o && (entry_count_o == MAX_SHOWN))
    else $error("refused add with table not full");

  // A stored add leaves at least one entry.
  a_stored_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && stored_o |-> (entry_count_o != '0) || (MAX_ENTRIES > 31))
    else $error("stored add left an empty count");

endmodule

bind peer_address_table pat_checker #(
  .MAX_ENTRIES (MAX_ENTRIES)
) u_pat_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .start         (start),
  .busy          (busy),
  .done_o        (done_o),
  .hit_o         (hit_o),
  .stored_o      (stored_o),
  .table_full_o  (table_full_o),
  .entry_count_o (entry_count_o)
);

`default_nettype wire

### tb/peer_address_table_test.sv
// Self-checking testbench for the peer address table: directed and random requests.
`timescale 1ns / 100ps

module peer_address_table_test;

  localparam int unsigned DEPTH = pat_pkg::MAX_ENTRIES_DEF;
  localparam int unsigned POOL_SIZE = 24;
  localparam int unsigned RANDOM_REQUESTS = 1200;
  localparam int unsigned DRAIN_CYCLES = 40;
  localparam int unsigned MAX_REPORTS = 60;

  // One expected outcome of a request, as the block shows it on its result ports.
  typedef struct packed {
    logic                            hit;
    logic                            stored;
    logic                            table_full;
    logic [pat_pkg::COUNT_OUT_W-1:0] entry_count;
  } pat_outcome_t;

  // Keeps a copy of the address table and the outcomes still owed by the block.
  class pat_scoreboard;
    logic [pat_pkg::ADDR_W-1:0] entries[DEPTH];
    int unsigned                live;
    pat_outcome_t               outcome_q[$];
    int unsigned                errors;
    int unsigned                reports;

    function new();
      live = 0;
      errors = 0;
      reports = 0;
    endfunction

    // Applies an accepted request to the table copy and queues its outcome.
    function void apply_command(pat_pkg::pat_op_e op, logic [pat_pkg::ADDR_W-1:0] addr);
      pat_outcome_t o;
      int pos;
      pos = -1;
      for (int i = 0; i < int'(live); i++) begin
        if (pos < 0 && entries[i] == addr) pos = i;
      end
      o = '0;
      o.hit = (pos >= 0);
      case (op)
        pat_pkg::OP_ADD: begin
          if (pos < 0) begin
            if (live < DEPTH) begin
              entries[live] = addr;
              live++;
              o.stored = 1'b1;
            end else begin
              o.table_full = 1'b1;
            end
          end
        end
        pat_pkg::OP_REMOVE: begin
          // The last entry fills the gap; removing the last one moves nothing.
          if (pos >= 0) begin
            live--;
            entries[pos] = entries[live];
          end
        end
        pat_pkg::OP_CLEAR: live = 0;
        default: ;
      endcase
      o.entry_count = pat_pkg::COUNT_OUT_W'(live);
      outcome_q.push_back(o);
    endfunction

    function void report(string field, longint unsigned exp, longint unsigned act);
      errors++;
      if (reports < MAX_REPORTS) begin
        reports++;
        $display("%0t: %s differs, expected %0d, actual %0d", $time, field, exp, act);
      end
    endfunction

    // Compares one result with the oldest outcome still owed.
    function void check_outcome(logic hit, logic stored, logic full,
                                logic [pat_pkg::COUNT_OUT_W-1:0] count);
      pat_outcome_t e;
      if (outcome_q.size() == 0) begin
        report("unexpected result, entry_count", 0, count);
        return;
      end
      e = outcome_q.pop_front();
      if (hit !== e.hit) report("hit", e.hit, hit);
      if (stored !== e.stored) report("stored", e.stored, stored);
      if (full !== e.table_full) report("table_full", e.table_full, full);
      if (count !== e.entry_count) report("entry_count", e.entry_count, count);
    endfunction

    function int unsigned pending();
      return outcome_q.size();
    endfunction
  endclass

  logic                            clk_i;
  logic                            rst_ni;
  logic                            start;
  logic                            busy;
  logic [pat_pkg::CMD_W-1:0]       command_i;
  logic [pat_pkg::ADDR_W-1:0]      mac_address_i;
  logic                            done_o;
  logic                            hit_o;
  logic                            stored_o;
  logic                            table_full_o;
  logic [pat_pkg::COUNT_OUT_W-1:0] entry_count_o;

  pat_scoreboard              sb;
  logic [pat_pkg::ADDR_W-1:0] pool[POOL_SIZE];

  peer_address_table #(
    .MAX_ENTRIES(DEPTH)
  ) dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start         (start),
    .busy          (busy),
    .command_i     (command_i),
    .mac_address_i (mac_address_i),
    .done_o        (done_o),
    .hit_o         (hit_o),
    .stored_o      (stored_o),
    .table_full_o  (table_full_o),
    .entry_count_o (entry_count_o)
  );

  // Clock with a 10 ns period.
  initial clk_i = 1'b0;
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Results are taken on the rising edge that ends their strobe cycle.
  always @(posedge clk_i) begin
    if (rst_ni && done_o) sb.check_outcome(hit_o, stored_o, table_full_o, entry_count_o);
  end

  // Watchdog for a hung block.
  initial begin
    #5_000_000;
    $display("Mismatches found");
    $finish;
  end

  function automatic logic [pat_pkg::ADDR_W-1:0] random_address();
    return {16'($urandom()), 32'($urandom())};
  endfunction

  // Mostly pool addresses so that hits and a full table are common.
  function automatic logic [pat_pkg::ADDR_W-1:0] pick_address();
    if ($urandom_range(0, 9) == 0) return random_address();
    return pool[$urandom_range(0, POOL_SIZE - 1)];
  endfunction

  // Presents a request and holds it until the block takes it.
  task automatic send_request(input pat_pkg::pat_op_e op,
                              input logic [pat_pkg::ADDR_W-1:0] addr);
    @(negedge clk_i);
    start <= 1'b1;
    command_i <= op;
    mac_address_i <= addr;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
    sb.apply_command(op, addr);
  endtask

  // Drops start and puts junk on the request fields for the idle stretch given by its argument.
  task automatic idle_for(input int unsigned cycles);
    @(negedge clk_i);
    start <= 1'b0;
    command_i <= pat_pkg::CMD_W'($urandom());
    mac_address_i <= random_address();
    repeat (cycles - 1) @(negedge clk_i);
  endtask

  initial begin
    logic [pat_pkg::ADDR_W-1:0] addr_a;
    int unsigned r;
    pat_pkg::pat_op_e op;
    sb = new();
    rst_ni = 1'b0;
    start = 1'b0;
    command_i = pat_pkg::OP_LOOKUP;
    mac_address_i = '0;

    // The pool holds both extremes and a pair that differs in a single bit.
    foreach (pool[i]) pool[i] = random_address();
    pool[0] = '0;
    pool[1] = '1;
    pool[2] = pool[3] ^ (48'd1 << $urandom_range(0, pat_pkg::ADDR_W - 1));
    addr_a = pool[4];

    repeat (11) @(posedge clk_i);
    @(negedge clk_i) rst_ni = 1'b1;

    // Directed requests: empty table, duplicates, moves on remove, clear with a hit.
    send_request(pat_pkg::OP_LOOKUP, '0);
    send_request(pat_pkg::OP_CLEAR, '0);
    send_request(pat_pkg::OP_ADD, '0);
    send_request(pat_pkg::OP_ADD, '1);
    send_request(pat_pkg::OP_ADD, '0);
    send_request(pat_pkg::OP_LOOKUP, '1);
    send_request(pat_pkg::OP_REMOVE, '0);
    send_request(pat_pkg::OP_REMOVE, addr_a);
    send_request(pat_pkg::OP_LOOKUP, '1);
    send_request(pat_pkg::OP_REMOVE, '1);
    send_request(pat_pkg::OP_ADD, addr_a);
    send_request(pat_pkg::OP_CLEAR, addr_a);
    send_request(pat_pkg::OP_LOOKUP, addr_a);

    // Random requests; a middle stretch runs back to back.
    for (int unsigned n = 0; n < RANDOM_REQUESTS; n++) begin
      r = $urandom_range(0, 199);
      if (r < 60) op = pat_pkg::OP_LOOKUP;
      else if (r < 140) op = pat_pkg::OP_ADD;
      else if (r < 197) op = pat_pkg::OP_REMOVE;
      else op = pat_pkg::OP_CLEAR;
      send_request(op, pick_address());
      if ((n < 400 || n >= 700) && $urandom_range(0, 99) < 11) begin
        idle_for($urandom_range(1, 6));
      end
    end

    @(negedge clk_i);
    start <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (sb.errors == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
